// ===== design/resident_page_table_defines.svh =====
// Assertion macros shared by the resident page table RTL.
`ifndef RESIDENT_PAGE_TABLE_DEFINES_SVH
`define RESIDENT_PAGE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define RPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("resident_page_table assertion failed");
// Checked on every rising clock edge, reset included.
`define RPT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("resident_page_table assertion failed");
`else
`define RPT_ASSERT(lbl, prop)
`define RPT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== design/rpt_pkg.sv =====
`default_nettype none

package rpt_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned PAGE_SHIFT = 12;

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned PNUM_W = 32 - PAGE_SHIFT;
  localparam int unsigned PAGE_W = 20;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned ST_W   = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_ADD_REF = 2'd2;
  localparam logic [1:0] OP_DROP    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_INVALID   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_IGNORED   = 3'd4;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [PNUM_W-1:0] pnum;
    logic [PAGE_W-1:0] page;
  } wr_req_t;

  typedef struct packed {
    logic              valid;
    logic [PNUM_W-1:0] pnum;
    logic [PAGE_W-1:0] page;
  } rd_data_t;

endpackage

`default_nettype wire

// ===== design/rpt_store.sv =====
`default_nettype none
`include "resident_page_table_defines.svh"

module rpt_store (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [rpt_pkg::IDX_W-1:0] rd_idx_i,
  output rpt_pkg::rd_data_t            rd_o,
  input  wire rpt_pkg::wr_req_t        wr_i,
  input  wire logic                    clr_i
);
  import rpt_pkg::*;

  logic [ENTRIES-1:0] valid_q;
  logic [PNUM_W-1:0]  pnum_q [ENTRIES];
  logic [PAGE_W-1:0]  page_q [ENTRIES];

  // Valid bits are the only part of the table that reset touches.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_i) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      pnum_q[wr_i.idx] <= wr_i.pnum;
      page_q[wr_i.idx] <= wr_i.page;
    end
  end

  assign rd_o.valid = valid_q[rd_idx_i];
  assign rd_o.pnum  = pnum_q[rd_idx_i];
  assign rd_o.page  = page_q[rd_idx_i];

  `RPT_ASSERT(a_no_write_on_clear, !(clr_i && wr_i.en))
  `RPT_ASSERT(a_clear_empties, clr_i |=> (valid_q == '0))
  `RPT_ASSERT(a_write_sets_valid, wr_i.en |=> valid_q[$past(wr_i.idx)])

endmodule

`default_nettype wire

// ===== design/rpt_engine.sv =====
`default_nettype none
`include "resident_page_table_defines.svh"

module rpt_engine (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                opcode_i,
  input  wire logic [31:0]               offset_i,
  input  wire logic [rpt_pkg::PAGE_W-1:0] page_id_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [rpt_pkg::ST_W-1:0]       status_o,
  output logic [rpt_pkg::PAGE_W-1:0]     page_out_o,
  output logic                           freed_o,
  output logic                           released_o,
  output logic                           last_o,
  output logic [rpt_pkg::IDX_W-1:0]      rd_idx_o,
  input  wire rpt_pkg::rd_data_t         rd_i,
  output rpt_pkg::wr_req_t               wr_o,
  output logic                           clr_o
);
  import rpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_INSERT,
    S_FREE,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [PNUM_W-1:0] pnum_q, pnum_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              free_found_q, free_found_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ST_W-1:0]   res_status_q, res_status_d;
  logic [PAGE_W-1:0] res_page_q, res_page_d;

  logic              out_valid_q, out_valid_d;
  logic [ST_W-1:0]   out_status_q, out_status_d;
  logic [PAGE_W-1:0] out_page_q, out_page_d;
  logic              out_freed_q, out_freed_d;
  logic              out_released_q, out_released_d;
  logic              out_last_q, out_last_d;

  logic              slot_free;
  logic              hit;
  logic              last_idx;
  logic              advance;
  logic              emit;
  logic [ST_W-1:0]   e_status;
  logic [PAGE_W-1:0] e_page;
  logic              e_freed;
  logic              e_last;

  assign slot_free = !out_valid_q || out_ready_i;
  // The single compare unit: stored page number against the requested one.
  assign hit       = rd_i.valid && (rd_i.pnum == pnum_q);
  assign last_idx  = (idx_q == IDX_W'(ENTRIES - 1));
  assign rd_idx_o  = idx_q;

  always_comb begin
    state_d      = state_q;
    pnum_d       = pnum_q;
    page_d       = page_q;
    idx_d        = idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_page_d   = res_page_q;
    wr_o         = '0;
    clr_o        = 1'b0;
    advance      = 1'b0;
    emit         = 1'b0;
    e_status     = ST_OK;
    e_page       = '0;
    e_freed      = 1'b0;
    e_last       = 1'b1;
    in_ready_o   = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pnum_d       = offset_i[31:PAGE_SHIFT];
          page_d       = page_id_i;
          idx_d        = '0;
          free_found_d = 1'b0;
          res_status_d = ST_OK;
          res_page_d   = '0;
          state_d      = S_EMIT;
          unique case (opcode_i)
            OP_LOOKUP: begin
              state_d = S_LOOKUP;
            end
            OP_INSERT: begin
              if (cnt_q == '0) begin
                res_status_d = ST_IGNORED;
              end else if (page_id_i == '0) begin
                res_status_d = ST_INVALID;
              end else begin
                state_d = S_INSERT;
              end
            end
            OP_ADD_REF: begin
              if (cnt_q == '0 || cnt_q == CNT_MAX) begin
                res_status_d = ST_IGNORED;
              end else begin
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            OP_DROP: begin
              if (cnt_q == '0) begin
                res_status_d = ST_IGNORED;
              end else begin
                cnt_d = cnt_q - CNT_W'(1);
                if (cnt_q == CNT_W'(1)) begin
                  state_d = S_FREE;
                end
              end
            end
          endcase
        end
      end
      S_LOOKUP: begin
        if (hit) begin
          res_page_d = rd_i.page;
          state_d    = S_EMIT;
        end else if (last_idx) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_EMIT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_INSERT: begin
        wr_o.pnum = pnum_q;
        wr_o.page = page_q;
        if (hit) begin
          wr_o.en  = 1'b1;
          wr_o.idx = idx_q;
          state_d  = S_EMIT;
        end else if (last_idx) begin
          // No match anywhere: fall back to the lowest free slot seen.
          if (free_found_q || !rd_i.valid) begin
            wr_o.en  = 1'b1;
            wr_o.idx = free_found_q ? free_idx_q : idx_q;
          end else begin
            res_status_d = ST_FULL;
          end
          state_d = S_EMIT;
        end else begin
          if (!rd_i.valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_q;
          end
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_FREE: begin
        if (rd_i.valid) begin
          emit    = 1'b1;
          e_page  = rd_i.page;
          e_freed = 1'b1;
          e_last  = 1'b0;
          advance = slot_free;
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          if (last_idx) begin
            clr_o   = 1'b1;
            state_d = S_EMIT;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      S_EMIT: begin
        emit     = 1'b1;
        e_status = res_status_q;
        e_page   = res_page_q;
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d    = out_valid_q;
    out_status_d   = out_status_q;
    out_page_d     = out_page_q;
    out_freed_d    = out_freed_q;
    out_released_d = out_released_q;
    out_last_d     = out_last_q;
    if (emit && slot_free) begin
      out_valid_d    = 1'b1;
      out_status_d   = e_status;
      out_page_d     = e_page;
      out_freed_d    = e_freed;
      out_released_d = e_last && (cnt_q == '0);
      out_last_d     = e_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= CNT_W'(1);
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      free_found_q   <= free_found_d;
      out_valid_q    <= out_valid_d;
      pnum_q         <= pnum_d;
      page_q         <= page_d;
      idx_q          <= idx_d;
      free_idx_q     <= free_idx_d;
      res_status_q   <= res_status_d;
      res_page_q     <= res_page_d;
      out_status_q   <= out_status_d;
      out_page_q     <= out_page_d;
      out_freed_q    <= out_freed_d;
      out_released_q <= out_released_d;
      out_last_q     <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign page_out_o  = out_page_q;
  assign freed_o     = out_freed_q;
  assign released_o  = out_released_q;
  assign last_o      = out_last_q;

  `RPT_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `RPT_ASSERT(a_freed_not_last, (out_valid_q && out_freed_q) |-> (!out_last_q && !out_released_q))
  `RPT_ASSERT(a_released_means_zero, (out_valid_q && out_released_q) |-> (cnt_q == '0))

endmodule

`default_nettype wire

// ===== design/resident_page_table.sv =====
// Resident page table: a small fully associative map from page-aligned
// byte offsets to page identifiers, plus the object's reference count.
// Input channel (in_valid_i/in_ready_o) carries opcode, offset and page id;
// output channel (out_valid_o/out_ready_i) carries status, page, freed,
// released and last. A transfer happens when valid and ready are both high.
// The block takes one item at a time. Reference and trivial cases go
// straight to the result. Lookup and insert step one entry per cycle
// through the single page-number comparator: lookup stops at the hit or
// at the last entry; insert scans every entry unless a match ends it early.
// A drop that reaches zero walks all ENTRIES slots, one freed transfer per
// valid entry, then clears the table and sends the final released result.
// Every item ends with exactly one result whose last flag is set.
// Results sit in an output register; a stalled receiver holds the scan and
// the sequencer where they are, and nothing is lost or repeated.
// Reset sets the reference count to one and marks every entry empty; the
// block comes out of reset idle and ready.
`default_nettype none

module resident_page_table (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                opcode_i,
  input  wire logic [31:0]               offset_i,
  input  wire logic [rpt_pkg::PAGE_W-1:0] page_id_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [rpt_pkg::ST_W-1:0]       status_o,
  output logic [rpt_pkg::PAGE_W-1:0]     page_out_o,
  output logic                           freed_o,
  output logic                           released_o,
  output logic                           last_o
);
  import rpt_pkg::*;

  logic [IDX_W-1:0] rd_idx;
  rd_data_t         rd_data;
  wr_req_t          wr_req;
  logic             clr;

  rpt_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd_data),
    .wr_i     (wr_req),
    .clr_i    (clr)
  );

  rpt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .offset_i    (offset_i),
    .page_id_i   (page_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .page_out_o  (page_out_o),
    .freed_o     (freed_o),
    .released_o  (released_o),
    .last_o      (last_o),
    .rd_idx_o    (rd_idx),
    .rd_i        (rd_data),
    .wr_o        (wr_req),
    .clr_o       (clr)
  );

endmodule

`default_nettype wire
